[rtl/wbss_pkg.sv]
// ----------------------------------------------------------------------------
// wbss_pkg
// Shared types and constants for the wildcard byte signature scanner.
// ----------------------------------------------------------------------------
package wbss_pkg;

    // fixed field widths
    localparam int ADDR_W    = 64;
    localparam int PAT_W     = 64;
    localparam int LEN_W     = 5;
    localparam int BYTE_W    = 8;
    localparam int TOTAL_W   = 33;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    // signature bytes held in the two pattern registers
    localparam int SIG_CAP = 16;

    // parameter defaults
    localparam int PATTERN_MAX_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 3'd0,
        CFG_PATTERN_HIGH   = 3'd1,
        CFG_PATTERN_LENGTH = 3'd2,
        CFG_WILDCARD       = 3'd3,
        CFG_BASE_ADDRESS   = 3'd4
    } cfg_reg_t;

endpackage

[rtl/wildcard_byte_signature_scan.sv]
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scan
// Streams scanned bytes and reports non-overlapping wildcard signature matches.
// ----------------------------------------------------------------------------
// One scanned byte is taken per item and the block sustains one item per
// clock cycle while no held result stalls it. Each item passes an input
// register, then a single compare stage that shifts it into a window of
// the newest PATTERN_MAX bytes and checks up to 16 signature bytes in
// parallel against that window. A result register holds the outcome.
// A result item appears only when a match ends on the byte or the byte is the
// last of its region; other bytes give no result. Matches are leftmost first
// and never overlap. A region longer than 2^OFFSET_BITS bytes stops
// producing matches. Configuration writes are always ready and must be
// issued only while no item is in flight.
module wildcard_byte_signature_scan
    import wbss_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // scanned byte channel
    input  logic                  scan_valid,
    output logic                  scan_stall,
    input  logic [BYTE_W-1:0]     scan_byte,
    input  logic                  last_byte,

    // result channel
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic                  match_found,
    output logic [ADDR_W-1:0]     match_address,
    output logic                  scan_done,
    output logic [TOTAL_W-1:0]    match_total
);

    // signature bytes actually usable
    localparam int SIG_MAX   = (PATTERN_MAX < SIG_CAP) ? PATTERN_MAX : SIG_CAP;
    localparam int WIN_IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    // offsets run from 0 up to and including 2^OFFSET_BITS
    localparam int OFF_W     = OFFSET_BITS + 1;
    // wide enough for a window position up to 64
    localparam int POS_W     = 7;

    // configuration registers
    logic [PAT_W-1:0]  pattern_low_reg;
    logic [PAT_W-1:0]  pattern_high_reg;
    logic [LEN_W-1:0]  pattern_length_reg;
    logic [BYTE_W-1:0] wildcard_reg;
    logic [ADDR_W-1:0] base_address_reg;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // region state
    logic [BYTE_W-1:0]  window_reg [PATTERN_MAX];
    logic [BYTE_W-1:0]  window_next [PATTERN_MAX];
    logic [OFF_W-1:0]   offset_reg;
    logic [OFF_W-1:0]   resume_reg;
    logic [TOTAL_W-1:0] counter_reg;

    // result register
    logic               res_valid_reg;
    logic               res_found_reg;
    logic [ADDR_W-1:0]  res_addr_reg;
    logic               res_done_reg;
    logic [TOTAL_W-1:0] res_total_reg;

    // compare stage
    logic                 advance;
    logic                 in_accept;
    logic [LEN_W-1:0]     eff_len;
    logic [2*PAT_W-1:0]   sig_bytes;
    logic                 sig_ok;
    logic                 in_range;
    logic [OFF_W-1:0]     offset_inc;
    logic [OFF_W-1:0]     start_offset;
    logic                 found;
    logic                 emit;
    logic [ADDR_W-1:0]    addr_next;
    logic [TOTAL_W-1:0]   counter_next;

    // ------------------------------------------------------------------
    // handshake: the compare stage moves unless a result is held up
    // ------------------------------------------------------------------
    assign advance    = !(res_valid_reg && result_stall);
    assign scan_stall = in_valid_reg && !advance;
    assign in_accept  = scan_valid && !scan_stall;
    assign cfg_ready  = 1'b1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= LEN_W'(1);
            wildcard_reg       <= '0;
            base_address_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                CFG_WILDCARD:       wildcard_reg       <= cfg_data[BYTE_W-1:0];
                CFG_BASE_ADDRESS:   base_address_reg   <= cfg_data;
                default:            ; // unknown index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // effective length: zero acts as one, capped at the usable bytes
    // ------------------------------------------------------------------
    always_comb
    begin
        if (pattern_length_reg == '0)
            eff_len = LEN_W'(1);
        else if (pattern_length_reg > LEN_W'(SIG_MAX))
            eff_len = LEN_W'(SIG_MAX);
        else
            eff_len = pattern_length_reg;
    end

    assign sig_bytes = {pattern_high_reg, pattern_low_reg};

    // ------------------------------------------------------------------
    // window shift and parallel signature compare
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [POS_W-1:0]     pos;
        logic [WIN_IDX_W-1:0] idx;
        logic [BYTE_W-1:0]    pat;

        window_next[0] = in_byte_reg;
        for (int i = 1; i < PATTERN_MAX; i++)
            window_next[i] = window_reg[i-1];

        // signature byte i lines up with window position len-1-i
        sig_ok = 1'b1;
        for (int i = 0; i < SIG_MAX; i++)
        begin
            pat = sig_bytes[BYTE_W*i +: BYTE_W];
            pos = POS_W'(eff_len) - POS_W'(i) - POS_W'(1);
            if (LEN_W'(i) < eff_len)
                idx = pos[WIN_IDX_W-1:0];
            else
                idx = '0;
            if ((LEN_W'(i) < eff_len) && (pat != wildcard_reg)
                && (pat != window_next[idx]))
                sig_ok = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // match position and bookkeeping
    // ------------------------------------------------------------------
    // the top offset bit is set only once the region hit its length cap
    assign in_range     = !offset_reg[OFF_W-1];
    assign offset_inc   = offset_reg + OFF_W'(1);
    assign start_offset = offset_inc - OFF_W'(eff_len);

    assign found = in_valid_reg && in_range && (offset_inc >= OFF_W'(eff_len))
                   && (start_offset >= resume_reg) && sig_ok;
    assign emit  = in_valid_reg && (found || in_last_reg);

    assign addr_next    = base_address_reg + ADDR_W'(start_offset);
    assign counter_next = (found && (counter_reg != '1)) ? counter_reg + TOTAL_W'(1)
                                                           : counter_reg;

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= scan_byte;
            in_last_reg <= last_byte;
        end
    end

    // ------------------------------------------------------------------
    // region state: offsets and match count restart after the last byte
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= '0;
            resume_reg  <= '0;
            counter_reg <= '0;
        end
        else if (advance && in_valid_reg)
        begin
            if (in_last_reg)
            begin
                offset_reg  <= '0;
                resume_reg  <= '0;
                counter_reg <= '0;
            end
            else
            begin
                if (in_range)
                    offset_reg <= offset_inc;
                if (found)
                    resume_reg <= offset_inc;
                counter_reg <= counter_next;
            end
        end
    end

    // window contents before the first full pattern are never compared
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            for (int i = 0; i < PATTERN_MAX; i++)
                window_reg[i] <= window_next[i];
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            res_found_reg <= found;
            res_addr_reg  <= found ? addr_next : '0;
            res_done_reg  <= in_last_reg;
            res_total_reg <= counter_next;
        end
    end

    assign result_valid  = res_valid_reg;
    assign match_found   = res_found_reg;
    assign match_address = res_addr_reg;
    assign scan_done     = res_done_reg;
    assign match_total   = res_total_reg;

endmodule

[rtl/wbss_checker.sv]
// ----------------------------------------------------------------------------
// wbss_port_checks
// Port-level checks for the wildcard byte signature scanner.
// ----------------------------------------------------------------------------
module wbss_port_checks
    import wbss_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  scan_valid,
    input logic                  scan_stall,
    input logic                  result_valid,
    input logic                  result_stall,
    input logic                  match_found,
    input logic [ADDR_W-1:0]     match_address,
    input logic                  scan_done,
    input logic [TOTAL_W-1:0]    match_total
);

    // a held result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(match_address)
            && $stable(match_total) && $stable(scan_done))
        else $error("stalled result changed");

    // input backs up only behind a blocked result
    assert property (@(posedge clk) disable iff (!rst_n)
        scan_stall |-> result_valid && result_stall)
        else $error("input stalled while output free");

    // a result that does not close the region must be a match
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !scan_done |-> match_found)
        else $error("empty result item");

    // no match means zero address
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !match_found |-> match_address == '0)
        else $error("address without match");

    // a match is always counted
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && match_found |-> match_total != '0)
        else $error("match not counted");

endmodule

bind wildcard_byte_signature_scan wbss_port_checks u_wbss_port_checks (.*);
